// File: design/dbnd_pkg.sv
package dbnd_pkg;

	localparam int DIGIT_W = 4;
	localparam int TDATA_W = 8;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
	localparam logic [DIGIT_W:0] DEC_BASE = 5'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAN,
		ST_CMP_RD,
		ST_CMP_EV,
		ST_SUB_RD,
		ST_SUB_EV,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} dbnd_state_t;

endpackage

// File: design/decimal_big_number_difference.sv
// Digits load at one item per cycle while the block is idle; no new digit is taken until
// the last result digit has gone. After the end-marked item the block finds the longer
// operand's digit count, compares the operands from the top weight down to the first digit
// where they differ, then subtracts every digit from weight zero up before its first result.
// Each result digit is read from the store, then offered until taken; one memory read per digit.
// Reset (arst_n low, asynchronous) clears both digit counts, the overflow flag and the
// state; the digit stores themselves are not cleared.
module decimal_big_number_difference #(
	parameter int MAX_DIGITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dbnd_pkg::TDATA_W-1:0]  s_tdata,  // [3:0] digit_in, [7:4] zero
	input  logic                          s_tuser,  // [0] func
	input  logic                          s_tlast,  // end_of_operands
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dbnd_pkg::TDATA_W-1:0]  m_tdata,  // [3:0] digit_out, [7:4] zero
	output logic                          m_tuser,  // [0] overflow
	output logic                          m_tlast   // last_digit
);
	import dbnd_pkg::*;

	// Counts must hold MAX_DIGITS itself; store indexes only need MAX_DIGITS-1.
	localparam int LW = $clog2(MAX_DIGITS + 1);
	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_DIGITS);
	localparam logic [LW-1:0] ONE = LW'(1);

	// Operand stores hold digits in arrival order, so the most significant digit sits
	// at index 0. The difference store is indexed by decimal weight.
	logic [DIGIT_W-1:0] mem_a [MAX_DIGITS];
	logic [DIGIT_W-1:0] mem_b [MAX_DIGITS];
	logic [DIGIT_W-1:0] mem_d [MAX_DIGITS];

	dbnd_state_t state_q, state_d;

	logic [LW-1:0]      len_a_q, len_b_q;
	logic               ovf_q;
	logic [LW-1:0]      span_q;
	logic [LW-1:0]      cnt_q;      // digit position walker, meaning depends on the pass
	logic [LW-1:0]      top_q;      // one above the highest nonzero difference digit
	logic               borrow_q;
	logic               swap_q;     // second operand is the larger one
	logic               za_q, zb_q; // position lies above an operand's length
	logic [DIGIT_W-1:0] rd_a_q, rd_b_q, rd_d_q;

	logic               in_acc, out_acc;
	logic [DIGIT_W-1:0] din_sat;
	logic [LW-1:0]      rd_pos;
	logic [LW-1:0]      addr_a_full, addr_b_full, addr_d_full;
	logic [DIGIT_W-1:0] opa, opb, big_d, small_d;
	logic [DIGIT_W:0]   sub_y, sub_r;
	logic               sub_brw;
	logic [LW-1:0]      top_nx;
	logic [LW-1:0]      span_nx;
	logic               cmp_done, sub_done;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Out-of-range digits saturate to nine.
	assign din_sat = (s_tdata[DIGIT_W-1:0] > DIGIT_MAX) ? DIGIT_MAX : s_tdata[DIGIT_W-1:0];

	// The compare pass walks weights downward and is one behind cnt_q; the subtract pass
	// walks weights upward from zero. Weight p of an operand sits at index len-1-p.
	assign rd_pos      = (state_q == ST_CMP_RD) ? cnt_q - ONE : cnt_q;
	assign addr_a_full = len_a_q - ONE - rd_pos;
	assign addr_b_full = len_b_q - ONE - rd_pos;
	assign addr_d_full = cnt_q - ONE;

	// Digits above an operand's length read as zero.
	assign opa = za_q ? '0 : rd_a_q;
	assign opb = zb_q ? '0 : rd_b_q;

	assign big_d   = swap_q ? opb : opa;
	assign small_d = swap_q ? opa : opb;

	// One decimal digit of subtraction with borrow.
	assign sub_y   = {1'b0, small_d} + {{DIGIT_W{1'b0}}, borrow_q};
	assign sub_brw = ({1'b0, big_d} < sub_y);
	assign sub_r   = sub_brw ? ({1'b0, big_d} + DEC_BASE - sub_y) : ({1'b0, big_d} - sub_y);
	assign top_nx  = (sub_r != '0) ? cnt_q + ONE : top_q;

	assign span_nx  = (len_a_q > len_b_q) ? len_a_q : len_b_q;
	assign cmp_done = (opa != opb) || (cnt_q == ONE);
	assign sub_done = (cnt_q + ONE == span_q);

	// Next state and handshake outputs.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_acc && s_tlast) begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN: begin
				state_d = ST_CMP_RD;
			end
			ST_CMP_RD: begin
				state_d = ST_CMP_EV;
			end
			ST_CMP_EV: begin
				state_d = cmp_done ? ST_SUB_RD : ST_CMP_RD;
			end
			ST_SUB_RD: begin
				state_d = ST_SUB_EV;
			end
			ST_SUB_EV: begin
				state_d = sub_done ? ST_EMIT_RD : ST_SUB_RD;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				m_tvalid = 1'b1;
				if (out_acc) begin
					state_d = (cnt_q == ONE) ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: digit counts, overflow flag, the pass walker and the compare and subtract state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q  <= '0;
			len_b_q  <= '0;
			ovf_q    <= 1'b0;
			span_q   <= '0;
			cnt_q    <= '0;
			top_q    <= '0;
			borrow_q <= 1'b0;
			swap_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!s_tuser) begin
							if (len_a_q < MAX_LEN) begin
								len_a_q <= len_a_q + ONE;
							end else begin
								ovf_q <= 1'b1;
							end
						end else begin
							if (len_b_q < MAX_LEN) begin
								len_b_q <= len_b_q + ONE;
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				ST_SPAN: begin
					span_q <= span_nx;
					cnt_q  <= span_nx;
					swap_q <= 1'b0;
				end
				ST_CMP_EV: begin
					if (cmp_done) begin
						swap_q   <= (opb > opa);
						cnt_q    <= '0;
						top_q    <= '0;
						borrow_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q - ONE;
					end
				end
				ST_SUB_EV: begin
					borrow_q <= sub_brw;
					top_q    <= top_nx;
					// An all-zero difference still emits its lowest digit.
					cnt_q    <= sub_done ? ((top_nx == '0) ? ONE : top_nx) : cnt_q + ONE;
				end
				ST_EMIT_OUT: begin
					if (out_acc) begin
						cnt_q <= cnt_q - ONE;
						if (cnt_q == ONE) begin
							len_a_q <= '0;
							len_b_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Digit stores: at most one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (in_acc && !s_tuser && (len_a_q < MAX_LEN)) begin
			mem_a[len_a_q[AW-1:0]] <= din_sat;
		end
		if (in_acc && s_tuser && (len_b_q < MAX_LEN)) begin
			mem_b[len_b_q[AW-1:0]] <= din_sat;
		end
		if (state_q == ST_SUB_EV) begin
			mem_d[cnt_q[AW-1:0]] <= sub_r[DIGIT_W-1:0];
		end
		rd_a_q <= mem_a[addr_a_full[AW-1:0]];
		rd_b_q <= mem_b[addr_b_full[AW-1:0]];
		if (state_q == ST_EMIT_RD) begin
			rd_d_q <= mem_d[addr_d_full[AW-1:0]];
		end
		if ((state_q == ST_CMP_RD) || (state_q == ST_SUB_RD)) begin
			za_q <= (rd_pos >= len_a_q);
			zb_q <= (rd_pos >= len_b_q);
		end
	end

	assign m_tdata = {{(TDATA_W-DIGIT_W){1'b0}}, rd_d_q};
	assign m_tlast = (cnt_q == ONE);
	assign m_tuser = ovf_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides active together");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[DIGIT_W-1:0] <= DIGIT_MAX))
		else $error("result digit above nine");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len_a_q <= MAX_LEN) && (len_b_q <= MAX_LEN))
		else $error("digit count beyond capacity");

	a_emit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_OUT) |-> (cnt_q != '0))
		else $error("emit walker at zero");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && (len_a_q == '0) && !ovf_q))
		else $error("block not cleared after final result");

endmodule

// File: tb/sv/testbench.sv
module testbench;
	import dbnd_pkg::*;

	// Digit capacity of each operand store; must match the parameter given to the block.
	localparam int DEPTH = 32;

	// The limit covers the block's longest computation before its first result, plus
	// the longest stall and margin, taken several times over.
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 200;

	// Operand select carried in tuser.
	localparam logic OP_FIRST = 1'b0;
	localparam logic OP_SECOND = 1'b1;

	// One item waiting to be sent. The gap is the idle time before it is offered.
	// When hold is set, the sender waits until every expected digit has come back.
	typedef struct {
		logic               func;
		logic [DIGIT_W-1:0] digit;
		logic               mark;
		int                 gap;
		bit                 hold;
	} digit_item_t;

	// One expected digit of the absolute difference.
	typedef struct {
		logic [DIGIT_W-1:0] digit;
		logic               last;
		logic               ovf;
	} diff_digit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;    // [3:0] digit_in, [7:4] zero
	logic               s_tuser = 1'b0;  // [0] func
	logic               s_tlast = 1'b0;  // end_of_operands
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;         // [3:0] digit_out, [7:4] zero
	logic               m_tuser;         // [0] overflow
	logic               m_tlast;         // last_digit

	decimal_big_number_difference #(
		.MAX_DIGITS(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	digit_item_t digit_send_q[$];
	diff_digit_t diff_digit_q[$];

	// Number of difference digits still owed by the block. It is updated once per edge
	// by the monitor, so the sender sees a stable value when it decides to hold.
	int owed_digits = 0;
	int errors = 0;
	int idle_cycles = 0;
	int queued_items = 0;

	// Predictor state: both operand stores, their digit counts and the dropped-digit flag.
	logic [DIGIT_W-1:0] operand_digits [2][DEPTH];
	int                 operand_len [2] = '{0, 0};
	bit                 digits_dropped = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	// Digit of weight 10^pos of a stored operand; zero above its length.
	function automatic int weight_digit(int which, int pos);
		if (pos >= operand_len[which])
			return 0;
		return operand_digits[which][operand_len[which] - 1 - pos];
	endfunction

	// Absorbs one accepted digit. On the end mark it compares the operands by value,
	// subtracts the smaller from the larger with decimal borrow and queues the digits
	// of the difference, most significant first with leading zeros suppressed.
	// Returns the number of digits queued.
	function automatic int absorb_digit(logic func, logic [DIGIT_W-1:0] raw, logic mark);
		logic [DIGIT_W-1:0] d;
		int                 diff [DEPTH];
		int                 which, span, pos, order, big, borrow, x, y, top, produced;
		diff_digit_t        r;
		// Anything above nine saturates to nine.
		d = (raw > DIGIT_MAX) ? DIGIT_MAX : raw;
		which = (func == OP_SECOND) ? 1 : 0;
		if (operand_len[which] < DEPTH) begin
			operand_digits[which][operand_len[which]] = d;
			operand_len[which]++;
		end else begin
			digits_dropped = 1'b1;
		end
		if (!mark)
			return 0;

		span = (operand_len[0] > operand_len[1]) ? operand_len[0] : operand_len[1];
		// Compare from the top weight down so that leading zeros do not count.
		order = 0;
		for (pos = span - 1; pos >= 0 && order == 0; pos--) begin
			x = weight_digit(0, pos);
			y = weight_digit(1, pos);
			if (x > y)
				order = 1;
			else if (y > x)
				order = -1;
		end
		big = (order >= 0) ? 0 : 1;

		borrow = 0;
		for (pos = 0; pos < span; pos++) begin
			x = weight_digit(big, pos);
			y = weight_digit(1 - big, pos) + borrow;
			if (x >= y) begin
				diff[pos] = x - y;
				borrow = 0;
			end else begin
				diff[pos] = x + int'(DEC_BASE) - y;
				borrow = 1;
			end
		end

		top = span;
		while (top > 0 && diff[top - 1] == 0)
			top--;

		produced = 0;
		if (top == 0) begin
			// Equal operands, or both empty: a single zero digit.
			r.digit = '0;
			r.last = 1'b1;
			r.ovf = digits_dropped;
			diff_digit_q.push_back(r);
			produced = 1;
		end else begin
			for (pos = top - 1; pos >= 0; pos--) begin
				r.digit = diff[pos][DIGIT_W-1:0];
				r.last = (pos == 0);
				r.ovf = digits_dropped;
				diff_digit_q.push_back(r);
				produced++;
			end
		end

		// Ready for the next pair.
		operand_len[0] = 0;
		operand_len[1] = 0;
		digits_dropped = 1'b0;
		return produced;
	endfunction

	// Random digit, mostly in range, sometimes ten to fifteen to exercise saturation.
	function automatic logic [DIGIT_W-1:0] random_digit();
		int r;
		r = $urandom_range(0, 31);
		if (r < 26)
			return DIGIT_W'(r % 10);
		return DIGIT_W'(r - 16);
	endfunction

	// Operand length: mostly short, now and then near or beyond the capacity.
	function automatic int random_length();
		if ($urandom_range(0, 24) == 0)
			return $urandom_range(DEPTH - 2, DEPTH + 4);
		return $urandom_range(0, 5);
	endfunction

	task automatic queue_digit(logic func, logic [DIGIT_W-1:0] d, logic mark, bit hold);
		digit_item_t it;
		bit          calm;
		// Every fourth stretch of 25 items goes out back to back.
		calm = ((queued_items / 25) % 4) == 3;
		it.func = func;
		it.digit = d;
		it.mark = mark;
		it.gap = calm ? 0 : $urandom_range(0, 14);
		it.hold = hold;
		digit_send_q.push_back(it);
		queued_items++;
	endtask

	// Queues a number written as hex characters, most significant first.
	task automatic queue_text(logic func, string text, logic mark_end, bit hold);
		logic [DIGIT_W-1:0] d;
		for (int k = 0; k < text.len(); k++) begin
			d = DIGIT_W'((text[k] >= "A") ? text[k] - "A" + 10 : text[k] - "0");
			queue_digit(func, d, mark_end && k == text.len() - 1, hold && k == 0);
		end
	endtask

	// Queues one operand pair. The second operand copies the first one's top `shared`
	// digits, so equal and nearly equal values are common. With scramble set, each
	// digit picks its operand at random, which also puts the end mark on first-operand
	// digits now and then.
	task automatic queue_pair(int n_first, int n_second, int shared, bit scramble, bit hold);
		logic [DIGIT_W-1:0] a [$];
		logic [DIGIT_W-1:0] b [$];
		logic               sel [$];
		logic [DIGIT_W-1:0] val [$];
		int                 lead, total;
		if (n_first + n_second == 0)
			n_second = 1;
		lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		for (int i = 0; i < n_first; i++)
			a.push_back(i < lead ? '0 : random_digit());
		lead = ($urandom_range(0, 3) == 0 && shared == 0) ? $urandom_range(1, 3) : 0;
		for (int i = 0; i < n_second; i++) begin
			if (i < shared && i < n_first)
				b.push_back(a[i]);
			else
				b.push_back(i < lead ? '0 : random_digit());
		end
		foreach (a[i]) begin
			sel.push_back(scramble ? logic'($urandom_range(0, 1)) : OP_FIRST);
			val.push_back(a[i]);
		end
		foreach (b[i]) begin
			sel.push_back(scramble ? logic'($urandom_range(0, 1)) : OP_SECOND);
			val.push_back(b[i]);
		end
		total = val.size();
		for (int i = 0; i < total; i++)
			queue_digit(sel[i], val[i], i == total - 1, hold && i == 0);
	endtask

	// Sender: offers the oldest pending item once its gap has run out.
	int gap_left = 0;
	bit gap_loaded = 1'b0;

	always @(posedge clk) begin
		digit_item_t nx;
		bit          fire;
		bit          go;
		if (arst_n) begin
			fire = s_tvalid && s_tready;
			if (!s_tvalid || fire) begin
				go = 1'b0;
				if (digit_send_q.size() != 0) begin
					if (!gap_loaded) begin
						gap_left = digit_send_q[0].gap;
						gap_loaded = 1'b1;
					end
					// A hold waits for the block to drain. An item taken at this very edge
					// may have just triggered a computation that the monitor has not
					// counted yet, so that edge never releases a hold.
					if (digit_send_q[0].hold && (fire || owed_digits != 0))
						go = 1'b0;
					else if (gap_left > 0)
						gap_left--;
					else
						go = 1'b1;
				end
				if (go) begin
					nx = digit_send_q.pop_front();
					gap_loaded = 1'b0;
					s_tdata <= {{(TDATA_W - DIGIT_W){1'b0}}, nx.digit};
					s_tuser <= nx.func;
					s_tlast <= nx.mark;
				end
				s_tvalid <= go;
			end
		end
	end

	// Receiver: after each digit taken, stalls for a random number of cycles, except
	// in every third stretch of 20 digits, where it takes everything at once.
	int stall_left = 0;
	int digits_taken = 0;

	always @(posedge clk) begin
		bit calm;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				digits_taken++;
				calm = ((digits_taken / 20) % 3) == 1;
				stall_left = calm ? 0 : $urandom_range(0, 14);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: checks each digit taken against the oldest expectation, then feeds the
	// item accepted at the same edge to the predictor.
	always @(posedge clk) begin
		diff_digit_t want;
		int          added;
		int          taken;
		if (arst_n) begin
			added = 0;
			taken = 0;
			if (m_tvalid && m_tready) begin
				if (diff_digit_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected digit %0d last %0b overflow %0b",
							$time, m_tdata, m_tlast, m_tuser);
				end else begin
					want = diff_digit_q.pop_front();
					taken = 1;
					if (m_tdata !== {{(TDATA_W - DIGIT_W){1'b0}}, want.digit} ||
							m_tlast !== want.last || m_tuser !== want.ovf) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: expected digit %0d last %0b overflow %0b,",
								" got digit %0d last %0b overflow %0b"}, $time,
								want.digit, want.last, want.ovf, m_tdata, m_tlast, m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready)
				added = absorb_digit(s_tuser, s_tdata[DIGIT_W-1:0], s_tlast);
			owed_digits <= owed_digits + added - taken;
		end
	end

	// Watchdog: ends the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int pairs;
		int r;
		int n_first;
		int n_second;
		bit hold;

		// Directed part.
		queue_text(OP_FIRST, "0", 1'b0, 1'b0);     // zero minus zero
		queue_text(OP_SECOND, "0", 1'b1, 1'b0);
		queue_text(OP_FIRST, "12", 1'b0, 1'b0);    // equal operands
		queue_text(OP_SECOND, "12", 1'b1, 1'b0);
		queue_text(OP_FIRST, "5", 1'b0, 1'b0);     // second larger and longer
		queue_text(OP_SECOND, "123", 1'b1, 1'b0);
		queue_text(OP_FIRST, "1000", 1'b0, 1'b1);  // borrow ripples; sent after a drain
		queue_text(OP_SECOND, "1", 1'b1, 1'b0);
		queue_text(OP_FIRST, "007", 1'b0, 1'b0);   // leading zeros, shorter by value
		queue_text(OP_SECOND, "12", 1'b1, 1'b0);
		queue_text(OP_FIRST, "F", 1'b0, 1'b0);     // both saturate to nine
		queue_text(OP_SECOND, "A", 1'b1, 1'b0);
		queue_text(OP_FIRST, "42", 1'b1, 1'b0);    // end mark on a first-operand digit
		queue_text(OP_SECOND, "7", 1'b1, 1'b0);    // empty first operand

		// Random part: mostly well-formed pairs, some scrambled. The first pair fills
		// both stores past capacity, sharing its top half so the compare walks deep.
		pairs = 0;
		while (queued_items < 130) begin
			hold = ($urandom_range(0, 9) == 0);
			if (pairs == 0) begin
				queue_pair(DEPTH + 2, DEPTH + 1, DEPTH / 2, 1'b0, 1'b1);
			end else begin
				r = $urandom_range(0, 9);
				n_first = random_length();
				n_second = random_length();
				if (r < 2)
					queue_pair(n_first, n_first, n_first, 1'b0, hold);
				else if (r < 4)
					queue_pair(n_first, n_second, $urandom_range(1, 5), 1'b0, hold);
				else if (r < 5)
					queue_pair(n_first, n_second, 0, 1'b1, hold);
				else
					queue_pair(n_first, n_second, 0, 1'b0, hold);
			end
			pairs++;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (digit_send_q.size() != 0 || s_tvalid || owed_digits != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0 && diff_digit_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
